### src/mead_pkg.sv
package mead_pkg;

  localparam int unsigned AddressBits = 5;
  localparam int unsigned TickWidth = 32;
  localparam int unsigned NodeAddrWidth = 5;
  localparam int unsigned SrcOutWidth = 5;
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned HeaderCntWidth = $clog2(2 * AddressBits + 1);

  localparam logic [NodeAddrWidth-1:0] NodeAddrReset = NodeAddrWidth'(17);
  localparam logic [TickWidth-1:0] LongGapMinReset = TickWidth'(10000);
  localparam logic [TickWidth-1:0] LongGapMaxReset = TickWidth'(20000);
  localparam logic [TickWidth-1:0] ShortGapMinReset = TickWidth'(1000);
  localparam logic [TickWidth-1:0] ShortGapMaxReset = TickWidth'(8000);

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_NODE_ADDRESS  = 3'd0,
    CFG_LONG_GAP_MIN  = 3'd1,
    CFG_LONG_GAP_MAX  = 3'd2,
    CFG_SHORT_GAP_MIN = 3'd3,
    CFG_SHORT_GAP_MAX = 3'd4
  } cfg_index_e;

  typedef enum logic [1:0] {
    FIELD_DEST    = 2'd0,
    FIELD_SRC     = 2'd1,
    FIELD_PAYLOAD = 2'd2
  } bit_field_e;

  typedef struct packed {
    logic                   action;
    logic                   edge_level;
    logic [TickWidth-1:0]   edge_tick;
  } in_item_t;

  typedef struct packed {
    logic                   bit_valid;
    logic                   bit_value;
    bit_field_e             bit_field;
    logic                   address_match;
    logic [SrcOutWidth-1:0] source_address;
    logic                   byte_valid;
    logic [7:0]             byte_value;
    logic                   frame_done;
  } out_item_t;

endpackage

### src/manchester_edge_decoder_addr_filter_unit.sv
// Each input passes through the input register and then the result register before its result is offered.
// Throughput: one item per cycle, limited only by the output stall.
// Each edge does one tick subtract and four window compares in a single stage.
// Reset clears the decoder state and the pipeline valids, and loads the
// configuration registers with their default values.
module manchester_edge_decoder_addr_filter_unit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   action_i,
  input  logic                                   edge_level_i,
  input  logic [mead_pkg::TickWidth-1:0]         edge_tick_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   bit_valid_o,
  output logic                                   bit_value_o,
  output logic [1:0]                             bit_field_o,
  output logic                                   address_match_o,
  output logic [mead_pkg::SrcOutWidth-1:0]       source_address_o,
  output logic                                   byte_valid_o,
  output logic [7:0]                             byte_value_o,
  output logic                                   frame_done_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [mead_pkg::CfgIndexWidth-1:0]     cfg_index_i,
  input  logic [mead_pkg::CfgDataWidth-1:0]      cfg_data_i
);
  import mead_pkg::*;

  logic [NodeAddrWidth-1:0]  node_addr_q;
  logic [TickWidth-1:0]      long_min_q, long_max_q, short_min_q, short_max_q;

  logic                      in_valid_q;
  in_item_t                  in_item_q;
  logic                      out_valid_q;
  out_item_t                 out_item_q, out_item_d;

  logic [TickWidth-1:0]      last_tick_q, last_tick_d;
  logic                      seen_q, seen_d;
  logic                      half_q, half_d;
  logic [HeaderCntWidth-1:0] hdr_cnt_q, hdr_cnt_d;
  logic [AddressBits-1:0]    dest_q, dest_d;
  logic [AddressBits-1:0]    src_q, src_d;
  logic                      match_q, match_d;
  logic [7:0]                byte_q, byte_d;
  logic [2:0]                bit_cnt_q, bit_cnt_d;

  logic                      out_load;
  logic                      step;
  logic [TickWidth-1:0]      gap;
  logic                      is_long, is_short, bit_fire;

  assign out_load    = !out_valid_q || !out_stall_i;
  assign step        = in_valid_q && out_load;
  assign in_stall_o  = in_valid_q && !out_load;
  assign cfg_ready_o = 1'b1;

  assign gap      = in_item_q.edge_tick - last_tick_q;
  assign is_long  = (gap >= long_min_q) && (gap <= long_max_q);
  assign is_short = (gap >= short_min_q) && (gap <= short_max_q);
  assign bit_fire = !in_item_q.action && seen_q && (is_long || (is_short && half_q));

  always_comb begin
    last_tick_d = last_tick_q;
    seen_d      = seen_q;
    half_d      = half_q;
    hdr_cnt_d   = hdr_cnt_q;
    dest_d      = dest_q;
    src_d       = src_q;
    match_d     = match_q;
    byte_d      = byte_q;
    bit_cnt_d   = bit_cnt_q;

    out_item_d            = '0;
    out_item_d.bit_field  = FIELD_DEST;

    if (in_item_q.action) begin
      out_item_d.frame_done     = 1'b1;
      out_item_d.address_match  = match_q;
      out_item_d.source_address = SrcOutWidth'(src_q);
      half_d    = 1'b0;
      hdr_cnt_d = '0;
      dest_d    = '0;
      src_d     = '0;
      match_d   = 1'b0;
      byte_d    = '0;
      bit_cnt_d = '0;
    end else begin
      seen_d      = 1'b1;
      last_tick_d = in_item_q.edge_tick;
      if (seen_q && !is_long && is_short && !half_q) begin
        half_d = 1'b1;
      end
      if (bit_fire) begin
        half_d                = 1'b0;
        out_item_d.bit_valid  = 1'b1;
        out_item_d.bit_value  = in_item_q.edge_level;
        if (hdr_cnt_q < HeaderCntWidth'(AddressBits)) begin
          out_item_d.bit_field = FIELD_DEST;
          dest_d    = {dest_q[AddressBits-2:0], in_item_q.edge_level};
          hdr_cnt_d = hdr_cnt_q + 1'b1;
          if (hdr_cnt_d == HeaderCntWidth'(AddressBits)) begin
            match_d = (dest_d == AddressBits'(node_addr_q));
          end
        end else if (hdr_cnt_q < HeaderCntWidth'(2 * AddressBits)) begin
          out_item_d.bit_field = FIELD_SRC;
          src_d     = {src_q[AddressBits-2:0], in_item_q.edge_level};
          hdr_cnt_d = hdr_cnt_q + 1'b1;
        end else begin
          out_item_d.bit_field = FIELD_PAYLOAD;
          if (match_q) begin
            byte_d    = {byte_q[6:0], in_item_q.edge_level};
            bit_cnt_d = bit_cnt_q + 1'b1;
            if (bit_cnt_d == 3'd0) begin
              out_item_d.byte_valid = 1'b1;
              out_item_d.byte_value = byte_d;
              byte_d                = '0;
            end
          end
        end
      end
      out_item_d.address_match  = match_d;
      out_item_d.source_address = SrcOutWidth'(src_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_addr_q <= NodeAddrReset;
      long_min_q  <= LongGapMinReset;
      long_max_q  <= LongGapMaxReset;
      short_min_q <= ShortGapMinReset;
      short_max_q <= ShortGapMaxReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_NODE_ADDRESS:  node_addr_q <= cfg_data_i[NodeAddrWidth-1:0];
        CFG_LONG_GAP_MIN:  long_min_q  <= cfg_data_i[TickWidth-1:0];
        CFG_LONG_GAP_MAX:  long_max_q  <= cfg_data_i[TickWidth-1:0];
        CFG_SHORT_GAP_MIN: short_min_q <= cfg_data_i[TickWidth-1:0];
        CFG_SHORT_GAP_MAX: short_max_q <= cfg_data_i[TickWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      last_tick_q <= '0;
      seen_q      <= 1'b0;
      half_q      <= 1'b0;
      hdr_cnt_q   <= '0;
      dest_q      <= '0;
      src_q       <= '0;
      match_q     <= 1'b0;
      byte_q      <= '0;
      bit_cnt_q   <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
      if (step) begin
        last_tick_q <= last_tick_d;
        seen_q      <= seen_d;
        half_q      <= half_d;
        hdr_cnt_q   <= hdr_cnt_d;
        dest_q      <= dest_d;
        src_q       <= src_d;
        match_q     <= match_d;
        byte_q      <= byte_d;
        bit_cnt_q   <= bit_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q.action     <= action_i;
      in_item_q.edge_level <= edge_level_i;
      in_item_q.edge_tick  <= edge_tick_i;
    end
    if (step) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign bit_valid_o      = out_item_q.bit_valid;
  assign bit_value_o      = out_item_q.bit_value;
  assign bit_field_o      = out_item_q.bit_field;
  assign address_match_o  = out_item_q.address_match;
  assign source_address_o = out_item_q.source_address;
  assign byte_valid_o     = out_item_q.byte_valid;
  assign byte_value_o     = out_item_q.byte_value;
  assign frame_done_o     = out_item_q.frame_done;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> bit_valid_o && address_match_o &&
      (bit_field_o == FIELD_PAYLOAD))
    else $error("Payload byte transfer without a matched payload bit.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> !bit_valid_o && !byte_valid_o)
    else $error("End of frame transfer carries a bit or a byte.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("Input stalled while the result register could advance.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !in_item_q.action |=> seen_q && (last_tick_q == $past(in_item_q.edge_tick)))
    else $error("Edge transfer did not record its tick.");
`endif

endmodule
